// ----- hdl/tgfr_pkg.sv -----
// Shared types, constants and the font table of the text glyph framebuffer renderer.
`timescale 1ns / 1ps

package tgfr_pkg;

   // Panel and font geometry.
   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 64;
   localparam int GLYPH_WIDTH   = 7;
   localparam int GLYPH_HEIGHT  = 10;
   localparam int LINE_PITCH    = 11;

   // Font table: ten rows of eight columns for each printable code.
   localparam int FONT_ROWS   = 10;
   localparam int FONT_BITS   = FONT_ROWS * 8;
   localparam int FONT_IDX_W  = $clog2(FONT_BITS);
   localparam int FIRST_CODE  = 32;
   localparam int LAST_CODE   = 126;
   localparam int GLYPH_COUNT = LAST_CODE - FIRST_CODE + 1;
   localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);

   // Store organization: pages of eight rows held as vertical bytes.
   localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int COL_W       = $clog2(SCREEN_WIDTH);
   localparam int ROW_W       = $clog2(SCREEN_HEIGHT);

   // A glyph cell touches at most this many pages.
   localparam int PAGE_SPAN   = (GLYPH_HEIGHT + 14) / 8;
   localparam int SPAN_W      = (PAGE_SPAN > 1) ? $clog2(PAGE_SPAN) : 1;
   localparam int PAGE_W      = $clog2(PAGE_COUNT + PAGE_SPAN);
   localparam int GCOL_W      = 3;
   localparam int Y_W         = PAGE_W + 3;

   // Stream payload layout.
   localparam int REQ_DATA_W  = 40;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 32;
   localparam int CURSOR_COL_W = 7;
   localparam int CURSOR_ROW_W = 6;

   typedef enum logic [1:0] {
      OP_DRAW_CHAR  = 2'd0,
      OP_DRAW_PIXEL = 2'd1,
      OP_CLEAR_HOME = 2'd2,
      OP_READ_BYTE  = 2'd3
   } tgfr_op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_GLYPH,
      ST_FLUSH,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_READ,
      ST_DONE
   } tgfr_state_type;

   // One read-modify-write step of a glyph cell.
   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [GCOL_W-1:0] col_off;
      logic [ROW_W-1:0]  top_row;
      logic              ink;
   } tgfr_step_type;

   // Row 0 sits in the top byte; bit 7 of each row is the leftmost column.
   localparam logic [FONT_BITS-1:0] FONT_ROM [0:GLYPH_COUNT-1] = '{
      80'h00_00_00_00_00_00_00_00_00_00,
      80'h10_10_10_10_10_10_00_10_00_00,
      80'h28_28_28_00_00_00_00_00_00_00,
      80'h24_24_7C_24_48_7C_48_48_00_00,
      80'h38_54_50_38_14_54_54_38_10_00,
      80'h20_54_58_30_28_54_14_08_00_00,
      80'h10_28_28_10_34_48_48_34_00_00,
      80'h10_10_10_00_00_00_00_00_00_00,
      80'h08_10_20_20_20_20_20_20_10_08,
      80'h20_10_08_08_08_08_08_08_10_20,
      80'h10_38_10_28_00_00_00_00_00_00,
      80'h00_00_10_10_7C_10_10_00_00_00,
      80'h00_00_00_00_00_00_00_10_10_10,
      80'h00_00_00_00_00_38_00_00_00_00,
      80'h00_00_00_00_00_00_00_10_00_00,
      80'h08_08_10_10_10_10_20_20_00_00,
      80'h38_44_44_54_44_44_44_38_00_00,
      80'h10_30_50_10_10_10_10_10_00_00,
      80'h38_44_44_04_08_10_20_7C_00_00,
      80'h38_44_04_18_04_04_44_38_00_00,
      80'h08_18_28_28_48_7C_08_08_00_00,
      80'h7C_40_40_78_04_04_44_38_00_00,
      80'h38_44_40_78_44_44_44_38_00_00,
      80'h7C_04_08_10_10_20_20_20_00_00,
      80'h38_44_44_38_44_44_44_38_00_00,
      80'h38_44_44_44_3C_04_44_38_00_00,
      80'h00_00_10_00_00_00_00_10_00_00,
      80'h00_00_00_10_00_00_00_10_10_10,
      80'h00_00_0C_30_40_30_0C_00_00_00,
      80'h00_00_00_7C_00_7C_00_00_00_00,
      80'h00_00_60_18_04_18_60_00_00_00,
      80'h38_44_04_08_10_10_00_10_00_00,
      80'h38_44_4C_54_5C_40_40_38_00_00,
      80'h10_28_28_28_28_7C_44_44_00_00,
      80'h78_44_44_78_44_44_44_78_00_00,
      80'h38_44_40_40_40_40_44_38_00_00,
      80'h70_48_44_44_44_44_48_70_00_00,
      80'h7C_40_40_7C_40_40_40_7C_00_00,
      80'h7C_40_40_78_40_40_40_40_00_00,
      80'h38_44_40_40_5C_44_44_38_00_00,
      80'h44_44_44_7C_44_44_44_44_00_00,
      80'h38_10_10_10_10_10_10_38_00_00,
      80'h04_04_04_04_04_04_44_38_00_00,
      80'h44_48_50_60_50_48_48_44_00_00,
      80'h40_40_40_40_40_40_40_7C_00_00,
      80'h44_6C_6C_54_44_44_44_44_00_00,
      80'h44_64_64_54_54_4C_4C_44_00_00,
      80'h38_44_44_44_44_44_44_38_00_00,
      80'h78_44_44_44_78_40_40_40_00_00,
      80'h38_44_44_44_44_44_54_38_04_00,
      80'h78_44_44_44_78_48_48_44_00_00,
      80'h38_44_40_30_08_04_44_38_00_00,
      80'h7C_10_10_10_10_10_10_10_00_00,
      80'h44_44_44_44_44_44_44_38_00_00,
      80'h44_44_44_28_28_28_10_10_00_00,
      80'h44_44_54_54_54_6C_28_28_00_00,
      80'h44_28_28_10_10_28_28_44_00_00,
      80'h44_44_28_28_10_10_10_10_00_00,
      80'h7C_04_08_10_10_20_40_7C_00_00,
      80'h18_10_10_10_10_10_10_10_10_18,
      80'h20_20_10_10_10_10_08_08_00_00,
      80'h30_10_10_10_10_10_10_10_10_30,
      80'h10_28_28_44_00_00_00_00_00_00,
      80'h00_00_00_00_00_00_00_00_00_FE,
      80'h20_10_00_00_00_00_00_00_00_00,
      80'h00_00_38_44_3C_44_4C_34_00_00,
      80'h40_40_58_64_44_44_64_58_00_00,
      80'h00_00_38_44_40_40_44_38_00_00,
      80'h04_04_34_4C_44_44_4C_34_00_00,
      80'h00_00_38_44_7C_40_44_38_00_00,
      80'h0C_10_7C_10_10_10_10_10_00_00,
      80'h00_00_34_4C_44_44_4C_34_04_78,
      80'h40_40_58_64_44_44_44_44_00_00,
      80'h10_00_70_10_10_10_10_10_00_00,
      80'h10_00_70_10_10_10_10_10_10_E0,
      80'h40_40_48_50_60_50_48_44_00_00,
      80'h70_10_10_10_10_10_10_10_00_00,
      80'h00_00_78_54_54_54_54_54_00_00,
      80'h00_00_58_64_44_44_44_44_00_00,
      80'h00_00_38_44_44_44_44_38_00_00,
      80'h00_00_58_64_44_44_64_58_40_40,
      80'h00_00_34_4C_44_44_4C_34_04_04,
      80'h00_00_58_64_40_40_40_40_00_00,
      80'h00_00_38_44_30_08_44_38_00_00,
      80'h20_20_78_20_20_20_20_18_00_00,
      80'h00_00_44_44_44_44_4C_34_00_00,
      80'h00_00_44_44_28_28_28_10_00_00,
      80'h00_00_54_54_54_6C_28_28_00_00,
      80'h00_00_44_28_10_10_28_44_00_00,
      80'h00_00_44_44_28_28_10_10_10_60,
      80'h00_00_7C_08_10_20_40_7C_00_00,
      80'h18_10_10_10_20_20_10_10_10_18,
      80'h10_10_10_10_10_10_10_10_10_10,
      80'h30_10_10_10_08_08_10_10_10_30,
      80'h00_00_00_74_4C_00_00_00_00_00
   };

endpackage

// ----- hdl/tgfr_glyph_merge.sv -----
// Merges one column of a glyph cell into a framebuffer byte of one page.
`timescale 1ns / 1ps

module tgfr_glyph_merge (
   input  logic [tgfr_pkg::FONT_BITS-1:0] glyph,
   input  tgfr_pkg::tgfr_step_type        step,
   input  logic [7:0]                     old_byte,
   output logic [7:0]                     new_byte
);
   import tgfr_pkg::*;

   // Each bit of the byte is one pixel row; rows inside the cell take the
   // font bit in the ink color or its inverse, all others keep their value.
   always_comb begin
      logic [Y_W-1:0]        pix_row;
      logic [Y_W-1:0]        top;
      logic [Y_W-1:0]        rel;
      logic                  hit;
      logic [FONT_IDX_W-1:0] pos;
      new_byte = old_byte;
      top = Y_W'(step.top_row);
      for (int k = 0; k < 8; k++) begin
         pix_row = {step.page, 3'(k)};
         rel = pix_row - top;
         hit = (pix_row >= top) && (rel < Y_W'(GLYPH_HEIGHT)) && (rel < Y_W'(FONT_ROWS));
         pos = FONT_IDX_W'(FONT_BITS - 1) - {rel[3:0], step.col_off};
         if (hit) begin
            new_byte[k] = ~(glyph[pos] ^ step.ink);
         end
      end
   end

endmodule

// ----- hdl/text_glyph_framebuffer_renderer.sv -----
// Top level of the text glyph framebuffer renderer: sequencer, frame store and stream ports.
`timescale 1ns / 1ps

// Channel   Direction  Payload
// req_      in         tuser: opcode; tdata: char_code, ink, pixel_x, pixel_y, read_addr
// rsp_      out        tdata: read_byte, echo_char, cursor_col, cursor_row
//
// A glyph does one read-modify-write per cycle on the frame store for each of
// 7 columns in 3 pages, plus setup, drain and response.
// A clear writes the store one byte a cycle.
// After reset the store is cleared in a pass with req_tready low.
// A pending response holds rsp_tdata; the next request is still accepted.
module text_glyph_framebuffer_renderer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] char_code, [8] ink, [16:9] pixel_x, [24:17] pixel_y, [34:25] read_addr
   input  logic [tgfr_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] opcode
   input  logic [tgfr_pkg::REQ_USER_W-1:0]     req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] read_byte, [15:8] echo_char, [22:16] cursor_col, [28:23] cursor_row
   output logic [tgfr_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import tgfr_pkg::*;

   tgfr_state_type state_ff, state_in;

   // Request fields.
   tgfr_op_type  op_ff, op_in;
   logic [7:0]   code_ff, code_in;
   logic         ink_ff, ink_in;
   logic [7:0]   px_ff, px_in;
   logic [7:0]   py_ff, py_in;
   logic [9:0]   raddr_ff, raddr_in;

   // Cursor, glyph and step counters.
   logic [COL_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [FONT_BITS-1:0]  glyph_ff, glyph_in;
   logic [SPAN_W-1:0]     po_ff, po_in;
   logic [GCOL_W-1:0]     cidx_ff, cidx_in;

   // Write stage of the glyph pipeline.
   logic                  wr_pend_ff, wr_pend_in;
   logic                  wr_ok_ff, wr_ok_in;
   logic [ADDR_W-1:0]     wr_addr_ff, wr_addr_in;
   tgfr_step_type         wr_step_ff, wr_step_in;

   logic [ADDR_W-1:0]     clr_cnt_ff, clr_cnt_in;
   logic                  clr_resp_ff, clr_resp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Frame store ports.
   logic [7:0]            frame_mem [0:STORE_BYTES-1];
   logic [7:0]            mem_q_ff;
   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_wr_addr;
   logic [ADDR_W-1:0]     mem_rd_addr;
   logic [7:0]            mem_wdata;

   logic                  req_accept;
   logic                  rsp_free;
   logic                  last_step;
   logic                  clr_last;
   tgfr_step_type         cur_step;
   logic [COL_W:0]        step_col;
   logic                  step_ok;
   logic [ADDR_W-1:0]     step_addr;
   logic                  pix_ok;
   logic [ADDR_W-1:0]     pix_addr;
   logic [7:0]            pix_mask;
   logic [7:0]            glyph_byte;
   logic [COL_W:0]        wrap_col_sum;
   logic [ROW_W+1:0]      wrap_row;
   logic [GLYPH_IDX_W-1:0] glyph_idx;
   logic [7:0]            read_byte;
   logic [7:0]            echo_char;

   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign last_step  = (po_ff == SPAN_W'(PAGE_SPAN - 1)) && (cidx_ff == GCOL_W'(GLYPH_WIDTH - 1));
   assign clr_last   = (clr_cnt_ff == ADDR_W'(STORE_BYTES - 1));

   // Address and bounds of the current glyph step.
   assign cur_step.page    = PAGE_W'(row_ff[ROW_W-1:3]) + PAGE_W'(po_ff);
   assign cur_step.col_off = cidx_ff;
   assign cur_step.top_row = row_ff;
   assign cur_step.ink     = ink_ff;
   assign step_col  = (COL_W+1)'(col_ff) + (COL_W+1)'(cidx_ff);
   assign step_ok   = (cur_step.page < PAGE_W'(PAGE_COUNT)) &&
                      (step_col < (COL_W+1)'(SCREEN_WIDTH));
   assign step_addr = ADDR_W'(int'(cur_step.page) * SCREEN_WIDTH + int'(step_col));

   // Address and mask of a single pixel.
   assign pix_ok   = (int'(px_ff) < SCREEN_WIDTH) && (int'(py_ff) < SCREEN_HEIGHT);
   assign pix_addr = ADDR_W'(int'(py_ff[7:3]) * SCREEN_WIDTH + int'(px_ff));
   assign pix_mask = 8'(1) << py_ff[2:0];

   // Glyph selection: codes outside the printable range fall back to a space.
   assign glyph_idx = ((int'(code_ff) >= FIRST_CODE) && (int'(code_ff) <= LAST_CODE)) ?
                      GLYPH_IDX_W'(int'(code_ff) - FIRST_CODE) : '0;

   tgfr_glyph_merge u_merge (
      .glyph    (glyph_ff),
      .step     (wr_step_ff),
      .old_byte (mem_q_ff),
      .new_byte (glyph_byte)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = clr_resp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (tgfr_op_type'(req_tuser[1:0]))
                  OP_DRAW_CHAR:  state_in = ST_SETUP;
                  OP_DRAW_PIXEL: state_in = ST_PIX_RD;
                  OP_CLEAR_HOME: state_in = ST_CLEAR;
                  default:       state_in = ST_READ;
               endcase
            end
         end
         ST_SETUP:  state_in = ST_GLYPH;
         ST_GLYPH: begin
            if (last_step) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH:  state_in = ST_DONE;
         ST_PIX_RD: state_in = ST_PIX_WR;
         ST_PIX_WR: state_in = ST_DONE;
         ST_READ:   state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Handshake and frame store controls.
   always_comb begin
      req_tready  = (state_ff == ST_IDLE);
      mem_we      = 1'b0;
      mem_wr_addr = wr_addr_ff;
      mem_wdata   = glyph_byte;
      mem_rd_addr = ADDR_W'(raddr_ff);
      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            mem_wdata   = '0;
         end
         ST_GLYPH, ST_FLUSH: begin
            mem_we = wr_pend_ff && wr_ok_ff;
            if (state_ff == ST_GLYPH) begin
               mem_rd_addr = step_addr;
            end
         end
         ST_PIX_RD: begin
            mem_rd_addr = pix_addr;
         end
         ST_PIX_WR: begin
            mem_we      = pix_ok;
            mem_wr_addr = pix_addr;
            mem_wdata   = ink_ff ? (mem_q_ff | pix_mask) : (mem_q_ff & ~pix_mask);
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      op_in        = op_ff;
      code_in      = code_ff;
      ink_in       = ink_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      raddr_in     = raddr_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      glyph_in     = glyph_ff;
      po_in        = po_ff;
      cidx_in      = cidx_ff;
      wr_pend_in   = 1'b0;
      wr_ok_in     = step_ok;
      wr_addr_in   = step_addr;
      wr_step_in   = cur_step;
      clr_cnt_in   = clr_cnt_ff;
      clr_resp_in  = clr_resp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wrap_col_sum = (COL_W+1)'(col_ff) + (COL_W+1)'(GLYPH_WIDTH);
      wrap_row     = (ROW_W+2)'(row_ff);
      read_byte    = (op_ff == OP_READ_BYTE) ? mem_q_ff : 8'd0;
      echo_char    = (op_ff == OP_DRAW_CHAR) ? code_ff : 8'd0;

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_accept) begin
               op_in    = tgfr_op_type'(req_tuser[1:0]);
               code_in  = req_tdata[7:0];
               ink_in   = req_tdata[8];
               px_in    = req_tdata[16:9];
               py_in    = req_tdata[24:17];
               raddr_in = req_tdata[34:25];
               if (tgfr_op_type'(req_tuser[1:0]) == OP_CLEAR_HOME) begin
                  col_in      = '0;
                  row_in      = '0;
                  clr_cnt_in  = '0;
                  clr_resp_in = 1'b1;
               end
            end
         end
         ST_SETUP: begin
            // Wrap to the next text line, then to the top left when full.
            if (wrap_col_sum >= (COL_W+1)'(SCREEN_WIDTH)) begin
               col_in   = '0;
               wrap_row = (ROW_W+2)'(row_ff) + (ROW_W+2)'(LINE_PITCH);
            end
            if (wrap_row + (ROW_W+2)'(GLYPH_HEIGHT) >= (ROW_W+2)'(SCREEN_HEIGHT)) begin
               col_in = '0;
               row_in = '0;
            end else begin
               row_in = wrap_row[ROW_W-1:0];
            end
            glyph_in = FONT_ROM[glyph_idx];
            po_in    = '0;
            cidx_in  = '0;
         end
         ST_GLYPH: begin
            // Issue the read of this step; its write follows in the next cycle.
            wr_pend_in = 1'b1;
            if (cidx_ff == GCOL_W'(GLYPH_WIDTH - 1)) begin
               cidx_in = '0;
               po_in   = po_ff + 1'b1;
            end else begin
               cidx_in = cidx_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            col_in = wrap_col_sum[COL_W-1:0];
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               clr_resp_in  = 1'b0;
               rsp_data_in  = RSP_DATA_W'({CURSOR_ROW_W'(row_ff), CURSOR_COL_W'(col_ff),
                                           echo_char, read_byte});
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         col_ff       <= '0;
         row_ff       <= '0;
         wr_pend_ff   <= 1'b0;
         clr_cnt_ff   <= '0;
         clr_resp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         wr_pend_ff   <= wr_pend_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_resp_ff  <= clr_resp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      code_ff     <= code_in;
      ink_ff      <= ink_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      raddr_ff    <= raddr_in;
      glyph_ff    <= glyph_in;
      po_ff       <= po_in;
      cidx_ff     <= cidx_in;
      wr_ok_ff    <= wr_ok_in;
      wr_addr_ff  <= wr_addr_in;
      wr_step_ff  <= wr_step_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Frame store: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_wr_addr] <= mem_wdata;
      end
      mem_q_ff <= frame_mem[mem_rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // No request is taken while the store is being cleared.
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_tready)
      else $error("request accepted during clear pass");

   // Glyph writes only drain inside the glyph sequence.
   a_wr_stage_scope: assert property (@(posedge clock) disable iff (reset)
      wr_pend_ff |-> (state_ff == ST_GLYPH || state_ff == ST_FLUSH))
      else $error("glyph write pending outside glyph sequence");

   // The text cursor always leaves room for a full cell below it.
   a_cursor_room: assert property (@(posedge clock) disable iff (reset)
      (int'(row_ff) + GLYPH_HEIGHT < SCREEN_HEIGHT) && (int'(col_ff) < SCREEN_WIDTH))
      else $error("text cursor outside the drawable area");

   // A response only appears after the completion state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside completion");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench of the text glyph framebuffer renderer, with its own framebuffer predictor.
`timescale 1ns / 1ps

module tb;
   import tgfr_pkg::*;

   // Panel and font geometry, kept apart from the design so that the predictor stands alone.
   localparam int PANEL_W    = 128;
   localparam int PANEL_H    = 64;
   localparam int CELL_W     = 7;
   localparam int CELL_H     = 10;
   localparam int PITCH      = 11;
   localparam int FB_BYTES   = 1024;

   // Run control.
   localparam int RANDOM_CMDS      = 1550;
   localparam int IDLE_PCT         = 26;
   localparam int QUIET_FIRST      = 700;
   localparam int QUIET_LAST       = 1000;
   localparam int HOLD_START       = 300;
   localparam int HOLD_CYCLES      = 400;
   localparam int DRAIN_CYCLES     = 64;
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int SHOWN_MISMATCHES = 10;

   typedef struct {
      tgfr_op_type op;
      logic [7:0]  char_code;
      logic        ink;
      logic [7:0]  pixel_x;
      logic [7:0]  pixel_y;
      logic [9:0]  read_addr;
   } text_cmd_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic [7:0] echo_char;
      logic [6:0] cursor_col;
      logic [5:0] cursor_row;
   } status_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Commands waiting to be sent, and the status words the renderer owes us.
   text_cmd_type text_cmds[$];
   text_cmd_type on_wire;
   status_type   predicted_status[$];

   // Shadow copy of the framebuffer and the text cursor.
   logic [7:0] shadow_fb [0:FB_BYTES-1];
   int         cursor_x;
   int         cursor_y;

   int cmd_total;
   int cmds_offered = 0;
   int cmds_taken = 0;
   int results_seen = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   text_glyph_framebuffer_renderer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bitmap of one printable character, row 0 in the top byte, bit 7 the leftmost column.
   // Codes outside the printable range come back blank, so they draw as a space.
   function automatic logic [79:0] glyph_bitmap(input logic [7:0] code);
      logic [79:0] rows;
      case (code)
         8'd32:  rows = 80'h00_00_00_00_00_00_00_00_00_00;
         8'd33:  rows = 80'h10_10_10_10_10_10_00_10_00_00;
         8'd34:  rows = 80'h28_28_28_00_00_00_00_00_00_00;
         8'd35:  rows = 80'h24_24_7C_24_48_7C_48_48_00_00;
         8'd36:  rows = 80'h38_54_50_38_14_54_54_38_10_00;
         8'd37:  rows = 80'h20_54_58_30_28_54_14_08_00_00;
         8'd38:  rows = 80'h10_28_28_10_34_48_48_34_00_00;
         8'd39:  rows = 80'h10_10_10_00_00_00_00_00_00_00;
         8'd40:  rows = 80'h08_10_20_20_20_20_20_20_10_08;
         8'd41:  rows = 80'h20_10_08_08_08_08_08_08_10_20;
         8'd42:  rows = 80'h10_38_10_28_00_00_00_00_00_00;
         8'd43:  rows = 80'h00_00_10_10_7C_10_10_00_00_00;
         8'd44:  rows = 80'h00_00_00_00_00_00_00_10_10_10;
         8'd45:  rows = 80'h00_00_00_00_00_38_00_00_00_00;
         8'd46:  rows = 80'h00_00_00_00_00_00_00_10_00_00;
         8'd47:  rows = 80'h08_08_10_10_10_10_20_20_00_00;
         8'd48:  rows = 80'h38_44_44_54_44_44_44_38_00_00;
         8'd49:  rows = 80'h10_30_50_10_10_10_10_10_00_00;
         8'd50:  rows = 80'h38_44_44_04_08_10_20_7C_00_00;
         8'd51:  rows = 80'h38_44_04_18_04_04_44_38_00_00;
         8'd52:  rows = 80'h08_18_28_28_48_7C_08_08_00_00;
         8'd53:  rows = 80'h7C_40_40_78_04_04_44_38_00_00;
         8'd54:  rows = 80'h38_44_40_78_44_44_44_38_00_00;
         8'd55:  rows = 80'h7C_04_08_10_10_20_20_20_00_00;
         8'd56:  rows = 80'h38_44_44_38_44_44_44_38_00_00;
         8'd57:  rows = 80'h38_44_44_44_3C_04_44_38_00_00;
         8'd58:  rows = 80'h00_00_10_00_00_00_00_10_00_00;
         8'd59:  rows = 80'h00_00_00_10_00_00_00_10_10_10;
         8'd60:  rows = 80'h00_00_0C_30_40_30_0C_00_00_00;
         8'd61:  rows = 80'h00_00_00_7C_00_7C_00_00_00_00;
         8'd62:  rows = 80'h00_00_60_18_04_18_60_00_00_00;
         8'd63:  rows = 80'h38_44_04_08_10_10_00_10_00_00;
         8'd64:  rows = 80'h38_44_4C_54_5C_40_40_38_00_00;
         8'd65:  rows = 80'h10_28_28_28_28_7C_44_44_00_00;
         8'd66:  rows = 80'h78_44_44_78_44_44_44_78_00_00;
         8'd67:  rows = 80'h38_44_40_40_40_40_44_38_00_00;
         8'd68:  rows = 80'h70_48_44_44_44_44_48_70_00_00;
         8'd69:  rows = 80'h7C_40_40_7C_40_40_40_7C_00_00;
         8'd70:  rows = 80'h7C_40_40_78_40_40_40_40_00_00;
         8'd71:  rows = 80'h38_44_40_40_5C_44_44_38_00_00;
         8'd72:  rows = 80'h44_44_44_7C_44_44_44_44_00_00;
         8'd73:  rows = 80'h38_10_10_10_10_10_10_38_00_00;
         8'd74:  rows = 80'h04_04_04_04_04_04_44_38_00_00;
         8'd75:  rows = 80'h44_48_50_60_50_48_48_44_00_00;
         8'd76:  rows = 80'h40_40_40_40_40_40_40_7C_00_00;
         8'd77:  rows = 80'h44_6C_6C_54_44_44_44_44_00_00;
         8'd78:  rows = 80'h44_64_64_54_54_4C_4C_44_00_00;
         8'd79:  rows = 80'h38_44_44_44_44_44_44_38_00_00;
         8'd80:  rows = 80'h78_44_44_44_78_40_40_40_00_00;
         8'd81:  rows = 80'h38_44_44_44_44_44_54_38_04_00;
         8'd82:  rows = 80'h78_44_44_44_78_48_48_44_00_00;
         8'd83:  rows = 80'h38_44_40_30_08_04_44_38_00_00;
         8'd84:  rows = 80'h7C_10_10_10_10_10_10_10_00_00;
         8'd85:  rows = 80'h44_44_44_44_44_44_44_38_00_00;
         8'd86:  rows = 80'h44_44_44_28_28_28_10_10_00_00;
         8'd87:  rows = 80'h44_44_54_54_54_6C_28_28_00_00;
         8'd88:  rows = 80'h44_28_28_10_10_28_28_44_00_00;
         8'd89:  rows = 80'h44_44_28_28_10_10_10_10_00_00;
         8'd90:  rows = 80'h7C_04_08_10_10_20_40_7C_00_00;
         8'd91:  rows = 80'h18_10_10_10_10_10_10_10_10_18;
         8'd92:  rows = 80'h20_20_10_10_10_10_08_08_00_00;
         8'd93:  rows = 80'h30_10_10_10_10_10_10_10_10_30;
         8'd94:  rows = 80'h10_28_28_44_00_00_00_00_00_00;
         8'd95:  rows = 80'h00_00_00_00_00_00_00_00_00_FE;
         8'd96:  rows = 80'h20_10_00_00_00_00_00_00_00_00;
         8'd97:  rows = 80'h00_00_38_44_3C_44_4C_34_00_00;
         8'd98:  rows = 80'h40_40_58_64_44_44_64_58_00_00;
         8'd99:  rows = 80'h00_00_38_44_40_40_44_38_00_00;
         8'd100: rows = 80'h04_04_34_4C_44_44_4C_34_00_00;
         8'd101: rows = 80'h00_00_38_44_7C_40_44_38_00_00;
         8'd102: rows = 80'h0C_10_7C_10_10_10_10_10_00_00;
         8'd103: rows = 80'h00_00_34_4C_44_44_4C_34_04_78;
         8'd104: rows = 80'h40_40_58_64_44_44_44_44_00_00;
         8'd105: rows = 80'h10_00_70_10_10_10_10_10_00_00;
         8'd106: rows = 80'h10_00_70_10_10_10_10_10_10_E0;
         8'd107: rows = 80'h40_40_48_50_60_50_48_44_00_00;
         8'd108: rows = 80'h70_10_10_10_10_10_10_10_00_00;
         8'd109: rows = 80'h00_00_78_54_54_54_54_54_00_00;
         8'd110: rows = 80'h00_00_58_64_44_44_44_44_00_00;
         8'd111: rows = 80'h00_00_38_44_44_44_44_38_00_00;
         8'd112: rows = 80'h00_00_58_64_44_44_64_58_40_40;
         8'd113: rows = 80'h00_00_34_4C_44_44_4C_34_04_04;
         8'd114: rows = 80'h00_00_58_64_40_40_40_40_00_00;
         8'd115: rows = 80'h00_00_38_44_30_08_44_38_00_00;
         8'd116: rows = 80'h20_20_78_20_20_20_20_18_00_00;
         8'd117: rows = 80'h00_00_44_44_44_44_4C_34_00_00;
         8'd118: rows = 80'h00_00_44_44_28_28_28_10_00_00;
         8'd119: rows = 80'h00_00_54_54_54_6C_28_28_00_00;
         8'd120: rows = 80'h00_00_44_28_10_10_28_44_00_00;
         8'd121: rows = 80'h00_00_44_44_28_28_10_10_10_60;
         8'd122: rows = 80'h00_00_7C_08_10_20_40_7C_00_00;
         8'd123: rows = 80'h18_10_10_10_20_20_10_10_10_18;
         8'd124: rows = 80'h10_10_10_10_10_10_10_10_10_10;
         8'd125: rows = 80'h30_10_10_10_08_08_10_10_10_30;
         8'd126: rows = 80'h00_00_00_74_4C_00_00_00_00_00;
         default: rows = '0;
      endcase
      return rows;
   endfunction

   // Set or clear one pixel of the shadow framebuffer; pixels off the panel are dropped.
   function automatic void plot_dot(input int x, input int y, input logic lit);
      int addr;
      if (x >= PANEL_W || y >= PANEL_H)
         return;
      addr = (y / 8) * PANEL_W + x;
      shadow_fb[addr][y % 8] = lit;
   endfunction

   // Apply one request to the shadow state and return the status word it should produce.
   function automatic status_type render_request(input text_cmd_type cmd);
      status_type  st;
      logic [79:0] rows;
      int          r;
      int          c;
      st = '0;
      case (cmd.op)
         OP_DRAW_CHAR: begin
            // Wrap to the next text line, then home when the panel is full.
            if (cursor_x + CELL_W >= PANEL_W) begin
               cursor_x = 0;
               cursor_y = cursor_y + PITCH;
            end
            if (cursor_y + CELL_H >= PANEL_H) begin
               cursor_x = 0;
               cursor_y = 0;
            end
            rows = glyph_bitmap(cmd.char_code);
            for (r = 0; r < CELL_H; r++)
               for (c = 0; c < CELL_W; c++)
                  plot_dot(cursor_x + c, cursor_y + r,
                           rows[79 - 8 * r - c] ? cmd.ink : ~cmd.ink);
            cursor_x = cursor_x + CELL_W;
            st.echo_char = cmd.char_code;
         end
         OP_DRAW_PIXEL: begin
            plot_dot(int'(cmd.pixel_x), int'(cmd.pixel_y), cmd.ink);
         end
         OP_CLEAR_HOME: begin
            for (r = 0; r < FB_BYTES; r++)
               shadow_fb[r] = '0;
            cursor_x = 0;
            cursor_y = 0;
         end
         OP_READ_BYTE: begin
            st.read_byte = shadow_fb[cmd.read_addr];
         end
         default: ;
      endcase
      st.cursor_col = 7'(cursor_x);
      st.cursor_row = 6'(cursor_y);
      return st;
   endfunction

   // Queue one request; the fields that the operation does not use are random.
   task automatic add_cmd(input tgfr_op_type op, input int arg_a, input int arg_b,
                          input logic ink);
      text_cmd_type cmd;
      cmd.op        = op;
      cmd.ink       = ink;
      cmd.char_code = 8'($urandom_range(0, 255));
      cmd.pixel_x   = 8'($urandom_range(0, 255));
      cmd.pixel_y   = 8'($urandom_range(0, 255));
      cmd.read_addr = 10'($urandom_range(0, FB_BYTES - 1));
      case (op)
         OP_DRAW_CHAR:  cmd.char_code = 8'(arg_a);
         OP_DRAW_PIXEL: begin
            cmd.pixel_x = 8'(arg_a);
            cmd.pixel_y = 8'(arg_b);
         end
         OP_READ_BYTE:  cmd.read_addr = 10'(arg_a);
         default: ;
      endcase
      text_cmds.push_back(cmd);
   endtask

   task automatic flag_mismatch(input string why, input status_type want,
                                input status_type got);
      mismatches++;
      if (mismatches <= SHOWN_MISMATCHES)
         $display("tb: %s at result %0d: expected byte %02h echo %02h col %0d row %0d,",
                  why, results_seen, want.read_byte, want.echo_char, want.cursor_col,
                  want.cursor_row, "\n    got byte %02h echo %02h col %0d row %0d",
                  got.read_byte, got.echo_char, got.cursor_col, got.cursor_row);
   endtask

   // Request driver: holds an offer until it is taken, idles at random between offers.
   always @(negedge clock) begin
      if (!reset && cmds_offered == cmds_taken) begin
         if (text_cmds.size() != 0 &&
             ((cmds_offered >= QUIET_FIRST && cmds_offered < QUIET_LAST) ||
              $urandom_range(0, 99) >= IDLE_PCT)) begin
            on_wire = text_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= on_wire.op;
            req_tdata  <= {{(REQ_DATA_W - 35){1'b0}}, on_wire.read_addr, on_wire.pixel_y,
                           on_wire.pixel_x, on_wire.ink, on_wire.char_code};
            cmds_offered++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response side ready: random stalls, one long hold-off, and a stretch with no stalls.
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && results_seen >= HOLD_START) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (results_seen >= QUIET_FIRST && results_seen < QUIET_LAST) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // Check each response against the oldest prediction, then predict for a new request.
   always @(posedge clock) begin : check_rsp
      status_type got;
      status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_byte  = rsp_tdata[7:0];
         got.echo_char  = rsp_tdata[15:8];
         got.cursor_col = rsp_tdata[22:16];
         got.cursor_row = rsp_tdata[28:23];
         if (predicted_status.size() == 0) begin
            flag_mismatch("response with no request pending", '0, got);
         end else begin
            want = predicted_status.pop_front();
            if (got.read_byte !== want.read_byte || got.echo_char !== want.echo_char ||
                got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row)
               flag_mismatch("mismatch", want, got);
         end
         results_seen++;
      end
      if (!reset && req_tvalid && req_tready) begin
         predicted_status.push_back(render_request(on_wire));
         cmds_taken++;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      int first_random;
      int pick;
      int code;
      int x;
      int y;

      for (x = 0; x < FB_BYTES; x++)
         shadow_fb[x] = '0;
      cursor_x = 0;
      cursor_y = 0;

      // Directed opening: blank store, glyphs of both inks, unprintable codes,
      // pixels at the panel corners and off the panel, then a clear.
      add_cmd(OP_READ_BYTE, 0, 0, 1'b0);
      add_cmd(OP_READ_BYTE, FB_BYTES - 1, 0, 1'b1);
      add_cmd(OP_DRAW_CHAR, 65, 0, 1'b1);
      add_cmd(OP_READ_BYTE, 3, 0, 1'b0);
      add_cmd(OP_READ_BYTE, PANEL_W + 3, 0, 1'b0);
      add_cmd(OP_DRAW_CHAR, 0, 0, 1'b1);
      add_cmd(OP_DRAW_CHAR, 255, 0, 1'b0);
      add_cmd(OP_READ_BYTE, 10, 0, 1'b0);
      add_cmd(OP_READ_BYTE, PANEL_W + 17, 0, 1'b1);
      add_cmd(OP_DRAW_CHAR, 126, 0, 1'b1);
      add_cmd(OP_DRAW_CHAR, 32, 0, 1'b0);
      add_cmd(OP_DRAW_CHAR, 31, 0, 1'b1);
      add_cmd(OP_DRAW_CHAR, 127, 0, 1'b0);
      add_cmd(OP_DRAW_PIXEL, 0, 0, 1'b1);
      add_cmd(OP_DRAW_PIXEL, PANEL_W - 1, PANEL_H - 1, 1'b1);
      add_cmd(OP_DRAW_PIXEL, PANEL_W, 5, 1'b1);
      add_cmd(OP_DRAW_PIXEL, 5, PANEL_H, 1'b1);
      add_cmd(OP_DRAW_PIXEL, 255, 255, 1'b1);
      add_cmd(OP_DRAW_PIXEL, 3, 9, 1'b0);
      add_cmd(OP_READ_BYTE, 0, 0, 1'b0);
      add_cmd(OP_READ_BYTE, FB_BYTES - 1, 0, 1'b0);
      add_cmd(OP_READ_BYTE, PANEL_W + 3, 0, 1'b1);
      add_cmd(OP_CLEAR_HOME, 0, 0, 1'b1);
      add_cmd(OP_READ_BYTE, 3, 0, 1'b0);

      // Random part: text in close to half the picks so the cursor wraps lines and the panel,
      // pixels often followed by a read of their byte, and rare clears.
      first_random = text_cmds.size();
      while (text_cmds.size() < first_random + RANDOM_CMDS) begin
         pick = $urandom_range(0, 999);
         if (pick < 4) begin
            add_cmd(OP_CLEAR_HOME, 0, 0, 1'($urandom_range(0, 1)));
         end else if (pick < 460) begin
            if ($urandom_range(0, 99) < 15)
               code = $urandom_range(0, 255);
            else
               code = $urandom_range(32, 126);
            add_cmd(OP_DRAW_CHAR, code, 0, 1'($urandom_range(0, 1)));
         end else if (pick < 620) begin
            if ($urandom_range(0, 3) == 0) begin
               x = $urandom_range(0, 255);
               y = $urandom_range(0, 255);
            end else begin
               x = $urandom_range(0, PANEL_W - 1);
               y = $urandom_range(0, PANEL_H - 1);
            end
            add_cmd(OP_DRAW_PIXEL, x, y, 1'($urandom_range(0, 1)));
            if (x < PANEL_W && y < PANEL_H && $urandom_range(0, 1) == 1)
               add_cmd(OP_READ_BYTE, (y / 8) * PANEL_W + x, 0, 1'($urandom_range(0, 1)));
         end else begin
            add_cmd(OP_READ_BYTE, $urandom_range(0, FB_BYTES - 1), 0,
                    1'($urandom_range(0, 1)));
         end
      end
      cmd_total = text_cmds.size();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and every status word to come back.
      while (cmds_taken != cmd_total)
         @(posedge clock);
      while (predicted_status.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/tgfr_pkg.sv
hdl/tgfr_glyph_merge.sv
hdl/text_glyph_framebuffer_renderer.sv
tb/tb.sv
